// ===== hdl/ca_pkg.sv =====
package ca_pkg;

  // Fixed field widths of the request and result items
  localparam int unsigned IdW      = 8;
  localparam int unsigned FieldW   = 32;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned LrnIdxW  = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic {
    OP_PREPARE = 1'b0,
    OP_ACCEPT  = 1'b1
  } op_e;

  typedef enum logic [KindW-1:0] {
    MSG_PREPARE_RSP = 2'd0,
    MSG_ACCEPT_RSP  = 2'd1,
    MSG_LEARN       = 2'd2
  } msg_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NODE_ID      = 1'b0,
    REG_LEARNER_MASK = 1'b1
  } cfg_reg_e;

  // Classified request handed from the front end to the emitter
  typedef struct packed {
    logic              is_accept;
    logic [IdW-1:0]    proposer;
    logic [FieldW-1:0] number;
    logic [FieldW-1:0] rep_num;
    logic [FieldW-1:0] rep_val;
    logic              rejected;
    logic [MaskW-1:0]  mask;
  } job_t;

endpackage

// ===== hdl/ca_ifs.sv =====
interface ca_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [ca_pkg::IdW-1:0]       proposer;
  logic [ca_pkg::FieldW-1:0]    prop_number;
  logic [ca_pkg::FieldW-1:0]    prop_value;

  modport source (output valid, operation, proposer, prop_number, prop_value,
                  input ready);
  modport sink   (input valid, operation, proposer, prop_number, prop_value,
                  output ready);
endinterface

interface ca_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ca_pkg::KindW-1:0]     message_kind;
  logic [ca_pkg::IdW-1:0]       sender_id;
  logic [ca_pkg::IdW-1:0]       target_proposer;
  logic [ca_pkg::LrnIdxW-1:0]   target_learner;
  logic [ca_pkg::FieldW-1:0]    echoed_number;
  logic [ca_pkg::FieldW-1:0]    reported_number;
  logic [ca_pkg::FieldW-1:0]    reported_value;
  logic                         rejected;
  logic                         last_of_run;

  modport source (output valid, message_kind, sender_id, target_proposer, target_learner,
                  echoed_number, reported_number, reported_value, rejected, last_of_run,
                  input ready);
  modport sink   (input valid, message_kind, sender_id, target_proposer, target_learner,
                  echoed_number, reported_number, reported_value, rejected, last_of_run,
                  output ready);
endinterface

interface ca_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ca_pkg::CfgIdxW-1:0]    index;
  logic [ca_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ca_front.sv =====
module ca_front #(
  parameter int unsigned NUM_LEARNERS = 8,
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ca_req_if.sink                    req_i,
  input  logic [ca_pkg::MaskW-1:0]  learner_mask_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output ca_pkg::job_t              job_o
);

  // Proposal numbers are kept modulo 2^NumW; the request field is 32 bits
  localparam int unsigned NumW = (NUMBER_WIDTH < ca_pkg::FieldW) ? NUMBER_WIDTH
                                                                 : ca_pkg::FieldW;
  localparam logic [ca_pkg::MaskW-1:0] LearnEn =
      (NUM_LEARNERS >= ca_pkg::MaskW) ? {ca_pkg::MaskW{1'b1}}
                                      : ca_pkg::MaskW'((1 << NUM_LEARNERS) - 1);

  logic [NumW-1:0]           promised_q, promised_d;
  logic [NumW-1:0]           acc_num_q, acc_num_d;
  logic [ca_pkg::FieldW-1:0] acc_val_q, acc_val_d;
  logic [NumW-1:0]           num;
  logic                      is_accept;
  logic                      grant;

  assign req_i.ready = !q_full_i;
  assign push_o      = req_i.valid && req_i.ready;

  assign num       = req_i.prop_number[NumW-1:0];
  assign is_accept = (ca_pkg::op_e'(req_i.operation) == ca_pkg::OP_ACCEPT);
  // Prepare needs a strictly higher number, accept at least the promise
  assign grant     = is_accept ? (num >= promised_q) : (num > promised_q);

  // Promise check, state update and classification
  always_comb begin
    promised_d = promised_q;
    acc_num_d  = acc_num_q;
    acc_val_d  = acc_val_q;

    job_o.is_accept = is_accept;
    job_o.proposer  = req_i.proposer;
    job_o.number    = ca_pkg::FieldW'(num);
    job_o.rejected  = !grant;
    job_o.rep_num   = '0;
    job_o.rep_val   = '0;
    job_o.mask      = '0;

    if (grant) begin
      promised_d = num;
      if (is_accept) begin
        acc_num_d     = num;
        acc_val_d     = req_i.prop_value;
        job_o.rep_num = ca_pkg::FieldW'(num);
        job_o.rep_val = req_i.prop_value;
        job_o.mask    = learner_mask_i & LearnEn;
      end else begin
        job_o.rep_num = ca_pkg::FieldW'(acc_num_q);
        job_o.rep_val = acc_val_q;
      end
    end
  end

  // Acceptor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      promised_q <= '0;
      acc_num_q  <= '0;
      acc_val_q  <= '0;
    end else if (push_o) begin
      promised_q <= promised_d;
      acc_num_q  <= acc_num_d;
      acc_val_q  <= acc_val_d;
    end
  end

  // An accepted number never runs ahead of the promise
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc_num_q <= promised_q)
    else $error("accepted number above promise");

  // The promise never goes down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_o |=> promised_q >= $past(promised_q))
    else $error("promise decreased");

endmodule

// ===== hdl/ca_queue.sv =====
module ca_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ca_pkg::job_t job_i,
  output logic         full_o,
  output logic         valid_o,
  output ca_pkg::job_t job_o,
  input  logic         pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ca_pkg::job_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// ===== hdl/ca_back.sv =====
module ca_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  ca_pkg::job_t              head_i,
  output logic                      pop_o,
  input  logic [ca_pkg::IdW-1:0]    node_id_i,
  ca_rsp_if.source                  rsp_o
);

  logic                        out_valid_q, out_valid_d;
  logic                        busy_q;
  logic [ca_pkg::MaskW-1:0]    rem_q;
  logic [ca_pkg::MaskW-1:0]    cur_rem;
  logic [ca_pkg::MaskW-1:0]    low_bit;
  logic [ca_pkg::LrnIdxW-1:0]  low_idx;
  logic                        step;
  logic                        do_learn;

  ca_pkg::msg_kind_e           kind_q;
  logic [ca_pkg::IdW-1:0]      sender_q;
  logic [ca_pkg::IdW-1:0]      proposer_q;
  logic [ca_pkg::LrnIdxW-1:0]  learner_q;
  logic [ca_pkg::FieldW-1:0]   echoed_q;
  logic [ca_pkg::FieldW-1:0]   rep_num_q;
  logic [ca_pkg::FieldW-1:0]   rep_val_q;
  logic                        rejected_q;
  logic                        last_q;

  // Output slot frees when empty or when the current result transfers
  assign step     = head_valid_i && (!out_valid_q || rsp_o.ready);
  assign cur_rem  = busy_q ? rem_q : head_i.mask;
  assign do_learn = (cur_rem != '0);
  assign pop_o    = step && !do_learn;
  assign low_bit  = cur_rem & (~cur_rem + 1'b1);

  // Lowest pending learner
  always_comb begin
    low_idx = '0;
    for (int i = ca_pkg::MaskW - 1; i >= 0; i--) begin
      if (cur_rem[i]) low_idx = ca_pkg::LrnIdxW'(i);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step)              out_valid_d = 1'b1;
    else if (rsp_o.ready)  out_valid_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        busy_q <= do_learn;
        rem_q  <= cur_rem & ~low_bit;
      end
    end
  end

  // Result register: learn messages first, response last
  always_ff @(posedge clk_i) begin
    if (step) begin
      sender_q <= node_id_i;
      if (do_learn) begin
        kind_q     <= ca_pkg::MSG_LEARN;
        proposer_q <= '0;
        learner_q  <= low_idx;
        echoed_q   <= '0;
        rep_num_q  <= head_i.rep_num;
        rep_val_q  <= head_i.rep_val;
        rejected_q <= 1'b0;
        last_q     <= 1'b0;
      end else begin
        kind_q     <= head_i.is_accept ? ca_pkg::MSG_ACCEPT_RSP : ca_pkg::MSG_PREPARE_RSP;
        proposer_q <= head_i.proposer;
        learner_q  <= '0;
        echoed_q   <= head_i.number;
        rep_num_q  <= head_i.is_accept ? '0 : head_i.rep_num;
        rep_val_q  <= head_i.is_accept ? '0 : head_i.rep_val;
        rejected_q <= head_i.rejected;
        last_q     <= 1'b1;
      end
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.message_kind    = kind_q;
  assign rsp_o.sender_id       = sender_q;
  assign rsp_o.target_proposer = proposer_q;
  assign rsp_o.target_learner  = learner_q;
  assign rsp_o.echoed_number   = echoed_q;
  assign rsp_o.reported_number = rep_num_q;
  assign rsp_o.reported_value  = rep_val_q;
  assign rsp_o.rejected        = rejected_q;
  assign rsp_o.last_of_run     = last_q;

  // A learn message is never the end of a run and never a refusal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && kind_q == ca_pkg::MSG_LEARN) |-> (!last_q && !rejected_q))
    else $error("malformed learn message");

  // A job stays at the queue head while its learn fan-out is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> head_valid_i)
    else $error("job lost during fan-out");

endmodule

// ===== hdl/consensus_acceptor_top.sv =====
// A request is written into the job queue; the emitter then loads each of its results
// into the output register, one result per cycle while rsp_o.ready is not held low.
// A request yields one result, or 1 + enabled learners for a granted accept.
// Requests are taken every cycle while the 2-entry job queue has room.
// Reset: asynchronous, active low; promise, accepted pair and config clear to 0.
module consensus_acceptor_top #(
  parameter int unsigned NUM_LEARNERS = 8,
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ca_req_if.sink     req_i,
  ca_rsp_if.source   rsp_o,
  ca_cfg_if.sink     cfg_i
);

  logic [ca_pkg::IdW-1:0]   node_id_q;
  logic [ca_pkg::MaskW-1:0] learner_mask_q;
  logic                     push;
  logic                     q_full;
  logic                     head_valid;
  logic                     pop;
  ca_pkg::job_t             job_in;
  ca_pkg::job_t             job_head;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= '0;
      learner_mask_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (ca_pkg::cfg_reg_e'(cfg_i.index))
        ca_pkg::REG_NODE_ID:      node_id_q      <= cfg_i.data;
        ca_pkg::REG_LEARNER_MASK: learner_mask_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  ca_front #(
    .NUM_LEARNERS (NUM_LEARNERS),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .learner_mask_i (learner_mask_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (job_in)
  );

  ca_queue #(
    .Depth (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .valid_o (head_valid),
    .job_o   (job_head),
    .pop_i   (pop)
  );

  ca_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (job_head),
    .pop_o         (pop),
    .node_id_i     (node_id_q),
    .rsp_o         (rsp_o)
  );

endmodule
